FILE: rtl/o1ae_pkg.sv
// Package for the order-1 arithmetic encoder: opcodes, sizes, store geometry.
// No dependencies.
package o1ae_pkg;

    localparam int DEF_COUNT_BITS = 17;
    localparam int DEF_PRECISION  = 32;
    localparam int NUM_SYMS       = 256;
    localparam int NUM_MODELS     = 257;
    localparam int STORE_DEPTH    = NUM_MODELS * NUM_SYMS;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int CNT_W          = 32;

    typedef enum logic [1:0] {
        OP_COUNT  = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

endpackage

FILE: rtl/o1ae_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module o1ae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/o1ae_muldiv.sv
// Iterative restoring divider forming floor(a*b/d), one quotient bit per cycle.
// The product is built by shift-add over b, one bit per cycle. No dependencies.
module o1ae_muldiv #(
    parameter int AW = 33,
    parameter int BW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    input  logic [BW-1:0] d,
    output logic          done,
    output logic [AW-1:0] q
);
    localparam int PW  = AW + BW;
    localparam int CW  = $clog2(PW + 1);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    md_state_t       state_reg, state_next;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [PW-1:0]   mcand_reg, mcand_next;
    logic [BW-1:0]   mplier_reg, mplier_next;
    logic [BW:0]     rem_reg, rem_next;
    logic [PW-1:0]   quo_reg, quo_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [BW:0]     trial;

    always_comb
    begin
        state_next  = state_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        trial       = {rem_reg[BW-1:0], prod_reg[PW-1]};
        unique case (state_reg)
            MD_IDLE:
            begin
                if (go)
                begin
                    prod_next   = '0;
                    mcand_next  = PW'(a);
                    mplier_next = b;
                    cnt_next    = CW'(BW);
                    state_next  = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (mplier_reg[0])
                    prod_next = prod_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = CW'(PW);
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                // one restoring step: shift in the next product bit
                prod_next = prod_reg << 1;
                if (trial >= {1'b0, d} && d != '0)
                begin
                    rem_next = trial - {1'b0, d};
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
    end

    assign done = done_reg;
    assign q    = quo_reg[AW-1:0];
endmodule

FILE: rtl/order1_arithmetic_encoder.sv
// Top level of the order-1 arithmetic encoder: sequencer, interval state, store.
// Depends on o1ae_pkg, o1ae_ram and o1ae_muldiv.
//
// Command-style block. Pulse start with opcode/symbol while busy is low; busy
// rises the next cycle and stays high until every result of the beat is out.
// Results appear on lead_bit/follow_bit/follow_count/last for one cycle each,
// marked by valid; the receiver cannot stall them, so capture every strobe.
// After reset the block clears its 65792-entry frequency store to one, one
// entry per cycle, with busy high. A count beat keeps busy high through its
// read, wait and saturating-write states. An encode beat walks the 256
// frequencies of its model through the single store port, runs the shared
// multiply/divide unit twice, then renormalizes one shift per cycle, at most
// PRECISION shifts and a closing stop check, and then updates the context.
// Each emitted run is held until the next run is formed or the shifts stop,
// so the final run of the beat carries last; the final run shows in the
// update cycle. A finish beat keeps busy high through the finish state and
// while its run is shown. Opcode 3 is accepted and dropped, and busy stays low.
module order1_arithmetic_encoder #(
    parameter int COUNT_BITS = o1ae_pkg::DEF_COUNT_BITS,
    parameter int PRECISION  = o1ae_pkg::DEF_PRECISION
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  opcode,
    input  logic [7:0]  symbol,
    output logic        busy,
    output logic        valid,
    output logic        lead_bit,
    output logic        follow_bit,
    output logic [31:0] follow_count,
    output logic        last
);
    import o1ae_pkg::*;

    localparam int TW = COUNT_BITS + 8;   // model total width
    localparam int SW = PRECISION + 1;    // span width
    localparam int IW = $clog2(PRECISION + 1);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_CRD    = 11'b00000000100,
        S_CWAIT  = 11'b00000001000,
        S_CWR    = 11'b00000010000,
        S_SCAN   = 11'b00000100000,
        S_DIVHI  = 11'b00001000000,
        S_DIVLO  = 11'b00010000000,
        S_UPD    = 11'b00100000000,
        S_RENORM = 11'b01000000000,
        S_FIN    = 11'b10000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [7:0]              sym_reg, sym_next;
    logic [PRECISION-1:0]    low_reg, low_next, high_reg, high_next;
    logic [CNT_W-1:0]        pend_reg, pend_next;
    logic [7:0]              cprev_reg, cprev_next, eprev_reg, eprev_next;
    logic                    cfirst_reg, cfirst_next, efirst_reg, efirst_next;
    logic [8:0]              scan_reg, scan_next;     // symbols issued
    logic [8:0]              seen_reg, seen_next;     // symbols received
    logic [TW-1:0]           tot_reg, tot_next, cumlo_reg, cumlo_next;
    logic [COUNT_BITS-1:0]   fsym_reg, fsym_next;
    logic [SW-1:0]           qhi_reg, qhi_next;
    logic [IW-1:0]           it_reg, it_next;
    logic                    mdgo_reg, mdgo_next;
    logic                    val_reg, val_next, lead_reg, lead_next;
    logic                    fol_reg, fol_next, last_reg, last_next;
    logic [CNT_W-1:0]        fcnt_reg, fcnt_next;
    // run held back until it is known whether another run follows
    logic                    hv_reg, hv_next, hl_reg, hl_next;
    logic [CNT_W-1:0]        hc_reg, hc_next;

    logic                    we;
    logic [COUNT_BITS-1:0]   wdata, rdata;
    logic [SW-1:0]           span;
    logic [TW-1:0]           md_b;
    logic                    md_done;
    logic [SW-1:0]           md_q;
    logic [ADDR_W-1:0]       base;
    logic [PRECISION-1:0]    lo_t, hi_t;
    logic                    emit, stop, upper;

    localparam logic [PRECISION-1:0] MID = PRECISION'(1) << (PRECISION - 1);
    localparam logic [PRECISION-1:0] Q1  = PRECISION'(1) << (PRECISION - 2);
    localparam logic [PRECISION-1:0] Q3  = MID + Q1;
    localparam logic [COUNT_BITS-1:0] FMAX = '1;
    localparam logic [CNT_W-1:0]      CMAX = '1;

    o1ae_ram #(.WIDTH(COUNT_BITS), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr_reg),
        .wdata (wdata),
        .rdata (rdata)
    );

    o1ae_muldiv #(.AW(SW), .BW(TW)) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mdgo_reg),
        .a     (span),
        .b     (md_b),
        .d     (tot_reg),
        .done  (md_done),
        .q     (md_q)
    );

    assign span = SW'({1'b0, high_reg} - {1'b0, low_reg} + 1'b1);
    assign md_b = (state_reg == S_DIVHI) ? cumlo_reg + TW'(fsym_reg) : cumlo_reg;

    // Renormalization decisions: a run goes out when the interval sits in
    // one half (the lower half wins when both hold), a pending step when it
    // straddles the middle quarter; else, or after PRECISION shifts, they stop.
    assign emit  = (it_reg != IW'(PRECISION)) && (high_reg < MID || low_reg >= MID);
    assign stop  = (it_reg == IW'(PRECISION))
                   || (!emit && !(low_reg >= Q1 && high_reg < Q3));
    assign upper = (high_reg >= MID);

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        sym_next    = sym_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        pend_next   = pend_reg;
        cprev_next  = cprev_reg;
        eprev_next  = eprev_reg;
        cfirst_next = cfirst_reg;
        efirst_next = efirst_reg;
        scan_next   = scan_reg;
        seen_next   = seen_reg;
        tot_next    = tot_reg;
        cumlo_next  = cumlo_reg;
        fsym_next   = fsym_reg;
        qhi_next    = qhi_reg;
        it_next     = it_reg;
        mdgo_next   = 1'b0;
        val_next    = 1'b0;
        lead_next   = lead_reg;
        fol_next    = fol_reg;
        last_next   = 1'b0;
        fcnt_next   = fcnt_reg;
        hv_next     = hv_reg;
        hl_next     = hl_reg;
        hc_next     = hc_reg;
        we          = 1'b0;
        wdata       = COUNT_BITS'(1);
        base        = '0;
        lo_t        = low_reg;
        hi_t        = high_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wdata = COUNT_BITS'(1);
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(STORE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    sym_next = symbol;
                    unique case (opcode_t'(opcode))
                        OP_COUNT:
                        begin
                            base = cfirst_reg ? '0 : ADDR_W'({cprev_reg, 8'd0}) + ADDR_W'(NUM_SYMS);
                            addr_next  = base + ADDR_W'(symbol);
                            state_next = S_CRD;
                        end
                        OP_ENCODE:
                        begin
                            base = efirst_reg ? '0 : ADDR_W'({eprev_reg, 8'd0}) + ADDR_W'(NUM_SYMS);
                            addr_next  = base;
                            scan_next  = 9'd1;
                            seen_next  = '0;
                            tot_next   = '0;
                            cumlo_next = '0;
                            state_next = S_SCAN;
                        end
                        OP_FINISH: state_next = S_FIN;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CRD:   state_next = S_CWAIT;
            S_CWAIT: state_next = S_CWR;
            S_CWR:
            begin
                // saturating increment, write back
                we = 1'b1;
                wdata = (rdata == FMAX) ? FMAX : rdata + 1'b1;
                cfirst_next = 1'b0;
                cprev_next  = sym_reg;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                // address leads data through the RAM's read register; rdata belongs to symbol seen_reg
                if (scan_reg < 9'd256)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg >= 9'd2)
                begin
                    if (seen_reg[7:0] == sym_reg)
                    begin
                        cumlo_next = tot_reg;
                        fsym_next  = rdata;
                    end
                    tot_next  = tot_reg + TW'(rdata);
                    seen_next = seen_reg + 1'b1;
                    if (seen_reg == 9'd255)
                    begin
                        mdgo_next  = 1'b1;
                        state_next = S_DIVHI;
                    end
                end
            end
            S_DIVHI:
            begin
                if (md_done)
                begin
                    qhi_next   = md_q;
                    mdgo_next  = 1'b1;
                    state_next = S_DIVLO;
                end
            end
            S_DIVLO:
            begin
                if (md_done)
                begin
                    high_next  = PRECISION'(SW'(low_reg) + qhi_reg - 1'b1);
                    low_next   = PRECISION'(SW'(low_reg) + md_q);
                    it_next    = '0;
                    state_next = S_RENORM;
                end
            end
            S_RENORM:
            begin
                // release the held run; it is the last one once the shifts stop
                if (hv_reg && (emit || stop))
                begin
                    val_next  = 1'b1;
                    last_next = stop;
                    lead_next = hl_reg;
                    fol_next  = !hl_reg;
                    fcnt_next = hc_reg;
                    hv_next   = 1'b0;
                end
                // one renormalization shift per cycle
                if (stop)
                    state_next = S_UPD;
                else if (emit)
                begin
                    hv_next   = 1'b1;
                    hl_next   = upper;
                    hc_next   = pend_reg;
                    pend_next = '0;
                    lo_t = upper ? low_reg - MID : low_reg;
                    hi_t = upper ? high_reg - MID : high_reg;
                    low_next  = lo_t << 1;
                    high_next = (hi_t << 1) | PRECISION'(1);
                    it_next   = it_reg + 1'b1;
                end
                else
                begin
                    if (pend_reg != CMAX)
                        pend_next = pend_reg + 1'b1;
                    low_next  = (low_reg - Q1) << 1;
                    high_next = ((high_reg - Q1) << 1) | PRECISION'(1);
                    it_next   = it_reg + 1'b1;
                end
            end
            S_UPD:
            begin
                efirst_next = 1'b0;
                eprev_next  = sym_reg;
                state_next  = S_IDLE;
            end
            S_FIN:
            begin
                val_next    = 1'b1;
                last_next   = 1'b1;
                lead_next   = (low_reg >= Q1);
                fol_next    = (low_reg < MID);
                fcnt_next   = (pend_reg != CMAX) ? pend_reg + 1'b1 : CMAX;
                low_next    = '0;
                high_next   = '1;
                pend_next   = '0;
                efirst_next = 1'b1;
                eprev_next  = '0;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            low_reg    <= '0;
            high_reg   <= '1;
            pend_reg   <= '0;
            cprev_reg  <= '0;
            eprev_reg  <= '0;
            cfirst_reg <= 1'b1;
            efirst_reg <= 1'b1;
            mdgo_reg   <= 1'b0;
            val_reg    <= 1'b0;
            last_reg   <= 1'b0;
            hv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            pend_reg   <= pend_next;
            cprev_reg  <= cprev_next;
            eprev_reg  <= eprev_next;
            cfirst_reg <= cfirst_next;
            efirst_reg <= efirst_next;
            mdgo_reg   <= mdgo_next;
            val_reg    <= val_next;
            last_reg   <= last_next;
            hv_reg     <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        scan_reg  <= scan_next;
        seen_reg  <= seen_next;
        tot_reg   <= tot_next;
        cumlo_reg <= cumlo_next;
        fsym_reg  <= fsym_next;
        qhi_reg   <= qhi_next;
        it_reg    <= it_next;
        lead_reg  <= lead_next;
        fol_reg   <= fol_next;
        fcnt_reg  <= fcnt_next;
        hl_reg    <= hl_next;
        hc_reg    <= hc_next;
    end

    // Busy covers the clear pass, every beat in flight and its final run.
    assign busy         = (state_reg != S_IDLE) || val_reg;
    assign valid        = val_reg;
    assign lead_bit     = lead_reg;
    assign follow_bit   = fol_reg;
    assign follow_count = fcnt_reg;
    assign last         = last_reg;

    // Follow bit is the inverse of the lead bit on every renormalization run.
    a_follow_inv: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ($past(state_reg) != S_FIN)) |-> (follow_bit != lead_bit))
        else $error("follow bit not inverse of lead");

    // A start is never taken while the store clear is running.
    a_no_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> busy)
        else $error("idle during clear");

    // The divider only finishes while the sequencer waits for it.
    a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == S_DIVHI || state_reg == S_DIVLO))
        else $error("divider done out of place");
endmodule
